### sv/bplc_pkg.sv
// Shared types and constants for the button press length classifier.
package bplc_pkg;

	// Width of the time-since-edge and hold counters
	localparam int unsigned CntW = 16;
	// Width used to compare the counters with the 16-bit limits
	localparam int unsigned CmpW = (CntW > 16) ? CntW : 16;
	// Saturation value of the counters
	localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

	// Configuration port widths
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_DEBOUNCE_TIME = 3'd0,
		CFG_SHORT_LIMIT   = 3'd1,
		CFG_LONG_LIMIT    = 3'd2,
		CFG_LED_TOTAL     = 3'd3,
		CFG_FREQ_TOTAL    = 3'd4
	} cfg_idx_t;

	// Release classification
	typedef enum logic [1:0] {
		PC_NONE   = 2'd0,
		PC_SHORT  = 2'd1,
		PC_MEDIUM = 2'd2,
		PC_LONG   = 2'd3
	} press_class_t;

	// Input action codes
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_EDGE = 1'b1;

	// Register reset values
	localparam logic [15:0] DebounceRst = 16'd100;
	localparam logic [15:0] ShortRst    = 16'd2000;
	localparam logic [15:0] LongRst     = 16'd4000;
	localparam logic [2:0]  LedTotalRst = 3'd6;
	localparam logic [2:0]  FreqTotRst  = 3'd3;

	// Configuration register contents
	typedef struct packed {
		logic [15:0] debounce_time;
		logic [15:0] short_limit;
		logic [15:0] long_limit;
		logic [2:0]  led_total;
		logic [2:0]  freq_total;
	} cfg_t;

	// One result beat
	typedef struct packed {
		logic [2:0]   led_number;
		logic         blink_mode;
		logic [1:0]   freq_index;
		logic         led_changed;
		logic         freq_changed;
		logic         light_request;
		press_class_t press_class;
	} result_t;

endpackage

### sv/bplc_cfg.sv
// Configuration register file of the button press length classifier.
module bplc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bplc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [bplc_pkg::CfgDataW-1:0]   cfg_data,
	output bplc_pkg::cfg_t                  cfg
);
	import bplc_pkg::*;

	cfg_t cfg_q;

	// Always able to take a write beat
	assign cfg_ready = 1'b1;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= DebounceRst;
			cfg_q.short_limit   <= ShortRst;
			cfg_q.long_limit    <= LongRst;
			cfg_q.led_total     <= LedTotalRst;
			cfg_q.freq_total    <= FreqTotRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEBOUNCE_TIME: cfg_q.debounce_time <= cfg_data[15:0];
				CFG_SHORT_LIMIT:   cfg_q.short_limit   <= cfg_data[15:0];
				CFG_LONG_LIMIT:    cfg_q.long_limit    <= cfg_data[15:0];
				CFG_LED_TOTAL:     cfg_q.led_total     <= cfg_data[2:0];
				CFG_FREQ_TOTAL:    cfg_q.freq_total    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/bplc_ctrl.sv
// Press timing state and release classification of the button press length classifier.
module bplc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                action,
	input  logic                level,
	input  bplc_pkg::cfg_t      cfg,
	output bplc_pkg::result_t   res
);
	import bplc_pkg::*;

	logic [CntW-1:0] since_edge_q, since_edge_d;
	logic [CntW-1:0] hold_time_q, hold_time_d;
	logic            held_q, held_d;
	logic [2:0]      led_q, led_d;
	logic            mode_q, mode_d;
	logic [1:0]      freq_q, freq_d;

	logic            edge_ok;
	logic [3:0]      led_inc;
	logic [2:0]      freq_inc;
	logic            is_short;
	logic            is_medium;

	// Debounce and hold length comparisons
	assign edge_ok   = CmpW'(since_edge_q) >= CmpW'(cfg.debounce_time);
	assign is_short  = CmpW'(hold_time_q) < CmpW'(cfg.short_limit);
	assign is_medium = CmpW'(hold_time_q) < CmpW'(cfg.long_limit);
	assign led_inc   = {1'b0, led_q} + 4'd1;
	assign freq_inc  = {1'b0, freq_q} + 3'd1;

	// Work out the next state and the result of this item
	always_comb begin
		since_edge_d      = since_edge_q;
		hold_time_d       = hold_time_q;
		held_d            = held_q;
		led_d             = led_q;
		mode_d            = mode_q;
		freq_d            = freq_q;
		res.led_changed   = 1'b0;
		res.freq_changed  = 1'b0;
		res.light_request = 1'b0;
		res.press_class   = PC_NONE;

		if (action == ACT_TICK) begin
			// Advance the time-since-edge counter, and the hold counter while held, holding at the top
			if (since_edge_q != CntMax)
				since_edge_d = since_edge_q + 1'b1;
			if (held_q && hold_time_q != CntMax)
				hold_time_d = hold_time_q + 1'b1;
		end else if (edge_ok) begin
			since_edge_d = '0;
			if (level && !held_q) begin
				held_d      = 1'b1;
				hold_time_d = '0;
			end else if (!level && held_q) begin
				held_d      = 1'b0;
				hold_time_d = '0;
				if (is_short) begin
					// Short press: next LED, wrap to the first
					led_d = (led_inc > {1'b0, cfg.led_total}) ? 3'd1 : led_inc[2:0];
					res.led_changed = 1'b1;
					res.press_class = PC_SHORT;
				end else if (is_medium) begin
					// Medium press: next frequency, only while blinking
					if (mode_q) begin
						freq_d = (freq_inc >= cfg.freq_total || freq_inc > 3'd3) ?
							2'd0 : freq_inc[1:0];
						res.freq_changed = 1'b1;
					end
					res.press_class = PC_MEDIUM;
				end else begin
					// Long press: toggle blink mode, light the LED on entering steady
					mode_d = ~mode_q;
					res.light_request = mode_q && (led_q != 3'd0) &&
						(led_q <= cfg.led_total);
					res.press_class = PC_LONG;
				end
			end
		end

		res.led_number = led_d;
		res.blink_mode = mode_d;
		res.freq_index = freq_d;
	end

	// Commit the state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_edge_q <= '0;
			hold_time_q  <= '0;
			held_q       <= 1'b0;
			led_q        <= 3'd1;
			mode_q       <= 1'b0;
			freq_q       <= 2'd0;
		end else if (step) begin
			since_edge_q <= since_edge_d;
			hold_time_q  <= hold_time_d;
			held_q       <= held_d;
			led_q        <= led_d;
			mode_q       <= mode_d;
			freq_q       <= freq_d;
		end
	end

endmodule

### sv/button_press_length_classifier.sv
// Top level of the button press length classifier: input register, state logic, result register.
// One result beat leaves for every input beat, in order. Each item is held in an input register,
// the timing state and release classification are evaluated in a single pass of logic, and
// the outcome lands in a result register, so a new item is taken in every cycle while the
// output side keeps up. When the output is stalled the result register holds and the input
// register keeps one further item, after which in_stall rises. Configuration writes are taken
// in any cycle with cfg_ready held high; write only while no item is in flight.
module button_press_length_classifier (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic                            button_level,
	// Result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      led_number,
	output logic                            blink_mode,
	output logic [1:0]                      freq_index,
	output logic                            led_changed,
	output logic                            freq_changed,
	output logic                            light_request,
	output logic [1:0]                      press_class,
	// Configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bplc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [bplc_pkg::CfgDataW-1:0]   cfg_data
);
	import bplc_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_s2;
	logic    valid_s1;
	logic    action_s1;
	logic    level_s1;
	logic    valid_s2;
	logic    adv;

	bplc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bplc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.action (action_s1),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Move the held item on when the result register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			action_s1 <= action;
			level_s1  <= button_level;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	// Drive the result beat
	assign out_valid     = valid_s2;
	assign led_number    = res_s2.led_number;
	assign blink_mode    = res_s2.blink_mode;
	assign freq_index    = res_s2.freq_index;
	assign led_changed   = res_s2.led_changed;
	assign freq_changed  = res_s2.freq_changed;
	assign light_request = res_s2.light_request;
	assign press_class   = res_s2.press_class;

	// A selected LED number is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> led_number != 3'd0)
		else $error("led_number is zero");

	// An LED step comes only with a short press
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && led_changed |-> press_class == PC_SHORT)
		else $error("led_changed without short press");

	// A frequency step comes only with a medium press in blink mode
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && freq_changed |-> press_class == PC_MEDIUM && blink_mode)
		else $error("freq_changed without medium press in blink mode");

	// A light request comes only with a long press that enters steady mode
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && light_request |-> press_class == PC_LONG && !blink_mode)
		else $error("light_request outside steady mode entry");

	// A held item is never lost while the result side is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && valid_s2)
		else $error("held item lost");

endmodule

### dv/tb_button_press_length_classifier.sv
// Self-checking testbench for the button press length classifier.
`timescale 1ns / 1ps

module tb_button_press_length_classifier;
	import bplc_pkg::*;

	localparam int CycleLimit = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_TICK;
	logic button_level = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] led_number;
	logic blink_mode;
	logic [1:0] freq_index;
	logic led_changed;
	logic freq_changed;
	logic light_request;
	logic [1:0] press_class;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = CFG_DEBOUNCE_TIME;
	logic [CfgDataW-1:0] cfg_data = '0;

	// Predicted configuration, reset values first
	logic [15:0] db_ticks = DebounceRst;
	logic [15:0] short_lim = ShortRst;
	logic [15:0] long_lim = LongRst;
	logic [2:0] led_cnt = LedTotalRst;
	logic [2:0] freq_cnt = FreqTotRst;

	// Predicted classifier state
	logic [CntW-1:0] gap_cnt = '0;
	logic [CntW-1:0] hold_cnt = '0;
	logic pressed = 1'b0;
	logic [2:0] led_sel = 3'd1;
	logic blinking = 1'b0;
	logic [1:0] freq_sel = '0;

	result_t expected_q[$];
	result_t expected_beat;
	int errors = 0;
	int cycle_cnt = 0;
	int beats_sent = 0;
	bit quiet = 1'b0;

	button_press_length_classifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.button_level(button_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.led_number(led_number),
		.blink_mode(blink_mode),
		.freq_index(freq_index),
		.led_changed(led_changed),
		.freq_changed(freq_changed),
		.light_request(light_request),
		.press_class(press_class),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Stall the result side at random, except in quiet stretches
	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 13);
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		errors++;
		if (errors <= 100)
			$display("cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result beat with none predicted", 16'(led_number), 16'd0);
			end else begin
				expected_beat = expected_q.pop_front();
				check_field("led_number", 16'(led_number),
					16'(expected_beat.led_number));
				check_field("blink_mode", 16'(blink_mode),
					16'(expected_beat.blink_mode));
				check_field("freq_index", 16'(freq_index),
					16'(expected_beat.freq_index));
				check_field("led_changed", 16'(led_changed),
					16'(expected_beat.led_changed));
				check_field("freq_changed", 16'(freq_changed),
					16'(expected_beat.freq_changed));
				check_field("light_request", 16'(light_request),
					16'(expected_beat.light_request));
				check_field("press_class", 16'(press_class),
					16'(expected_beat.press_class));
			end
		end
	end

	// Advance the timing state and classify a release
	task automatic classify_item(input logic act, input logic lvl, output result_t res);
		logic [3:0] led_nxt;
		logic [2:0] freq_nxt;
		res = '0;
		res.press_class = PC_NONE;
		if (act == ACT_TICK) begin
			if (gap_cnt != CntMax)
				gap_cnt++;
			if (pressed && hold_cnt != CntMax)
				hold_cnt++;
		end else if (gap_cnt >= db_ticks) begin
			gap_cnt = '0;
			if (lvl && !pressed) begin
				pressed = 1'b1;
				hold_cnt = '0;
			end else if (!lvl && pressed) begin
				pressed = 1'b0;
				if (hold_cnt < short_lim) begin
					led_nxt = {1'b0, led_sel} + 4'd1;
					led_sel = (led_nxt > led_cnt) ? 3'd1 : led_nxt[2:0];
					res.led_changed = 1'b1;
					res.press_class = PC_SHORT;
				end else if (hold_cnt < long_lim) begin
					if (blinking) begin
						freq_nxt = {1'b0, freq_sel} + 3'd1;
						freq_sel = (freq_nxt >= freq_cnt || freq_nxt > 3'd3) ? 2'd0 : freq_nxt[1:0];
						res.freq_changed = 1'b1;
					end
					res.press_class = PC_MEDIUM;
				end else begin
					blinking = !blinking;
					if (!blinking && led_sel >= 3'd1 && led_sel <= led_cnt)
						res.light_request = 1'b1;
					res.press_class = PC_LONG;
				end
				hold_cnt = '0;
			end
		end
		res.led_number = led_sel;
		res.blink_mode = blinking;
		res.freq_index = freq_sel;
	endtask

	// Send one beat, with an occasional gap in front; valid stays high afterwards
	task automatic send_beat(input logic act, input logic lvl);
		result_t res;
		if (!quiet && $urandom_range(99) < 13) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		button_level <= lvl;
		do @(posedge clk); while (in_stall);
		classify_item(act, lvl, res);
		expected_q.push_back(res);
		beats_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_beat(ACT_TICK, 1'($urandom_range(1)));
	endtask

	// Idle the ticks, press, hold for some ticks, release
	task automatic press_for(input int gap, input int hold_ticks);
		send_ticks(gap);
		send_beat(ACT_EDGE, 1'b1);
		send_ticks(hold_ticks);
		send_beat(ACT_EDGE, 1'b0);
	endtask

	// Drop valid and wait until every predicted beat has come back
	task automatic drain_results;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		CFG_DEBOUNCE_TIME: db_ticks = val;
		CFG_SHORT_LIMIT: short_lim = val;
		CFG_LONG_LIMIT: long_lim = val;
		CFG_LED_TOTAL: led_cnt = val[2:0];
		CFG_FREQ_TOTAL: freq_cnt = val[2:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reprogram every register once the pipeline is empty; junk in the unused upper bits
	task automatic set_config(input logic [15:0] db, input logic [15:0] sl,
			input logic [15:0] ll, input logic [2:0] lt, input logic [2:0] ft);
		drain_results();
		write_reg(CFG_DEBOUNCE_TIME, db);
		write_reg(CFG_SHORT_LIMIT, sl);
		write_reg(CFG_LONG_LIMIT, ll);
		write_reg(CFG_LED_TOTAL, {13'($urandom), lt});
		write_reg(CFG_FREQ_TOTAL, {13'($urandom), ft});
	endtask

	// Reset values of debounce and short limit: early edge, short press, edge one tick early
	task automatic test_reset_defaults;
		send_beat(ACT_EDGE, 1'b1);
		press_for(100, 110);
		press_for(99, 120);
	endtask

	// Each class of release and the edges that repeat the current level
	task automatic test_press_classes;
		set_config(16'd0, 16'd2, 16'd4, 3'd7, 3'd4);
		press_for(0, 0);
		press_for(0, 1);
		press_for(0, 2);
		press_for(0, 4);
		press_for(0, 3);
		send_beat(ACT_EDGE, 1'b0);
		send_beat(ACT_EDGE, 1'b1);
		send_beat(ACT_EDGE, 1'b1);
		send_beat(ACT_EDGE, 1'b0);
		press_for(0, 4);
	endtask

	// Edges too soon after the last accepted one are dropped
	task automatic test_debounce;
		set_config(16'd3, 16'd2, 16'd4, 3'd6, 3'd3);
		send_ticks(3);
		send_beat(ACT_EDGE, 1'b1);
		send_ticks(2);
		send_beat(ACT_EDGE, 1'b0);
		send_ticks(1);
		send_beat(ACT_EDGE, 1'b0);
		send_ticks(2);
		send_beat(ACT_EDGE, 1'b1);
	endtask

	// Short test wins over long test; extreme limits
	task automatic test_limit_order;
		set_config(16'd0, 16'd8, 16'd2, 3'd6, 3'd3);
		press_for(0, 5);
		press_for(0, 9);
		set_config(16'd0, 16'd0, 16'd0, 3'd6, 3'd3);
		press_for(0, 0);
		set_config(16'd0, 16'hFFFF, 16'hFFFF, 3'd6, 3'd3);
		press_for(0, 7);
	endtask

	// LED and frequency wrap, zero and oversized totals, light request gating
	task automatic test_wraps_and_light;
		set_config(16'd0, 16'd1, 16'd2, 3'd7, 3'd4);
		repeat (8) press_for(0, 0);
		if (!blinking)
			press_for(0, 2);
		repeat (5) press_for(0, 1);
		set_config(16'd0, 16'd1, 16'd2, 3'd7, 3'd7);
		repeat (5) press_for(0, 1);
		set_config(16'd0, 16'd1, 16'd2, 3'd0, 3'd0);
		repeat (2) press_for(0, 0);
		repeat (2) press_for(0, 1);
		repeat (2) press_for(0, 2);
		set_config(16'd0, 16'd1, 16'd2, 3'd7, 3'd5);
		while (led_sel != 3'd7) press_for(0, 0);
		drain_results();
		write_reg(CFG_LED_TOTAL, 16'd3);
		repeat (2) press_for(0, 2);
		drain_results();
		// Writes to indexes past the last register change nothing
		for (int k = CFG_FREQ_TOTAL + 1; k < (1 << CfgIdxW); k++)
			write_reg(k[CfgIdxW-1:0], 16'($urandom));
		repeat (2) press_for(0, 2);
	endtask

	// Mostly well-formed presses with random timing, some noise, several settings
	task automatic test_random;
		int start;
		int db;
		int ll;
		for (int phase = 0; phase < 12; phase++) begin
			db = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
			ll = $urandom_range(16);
			set_config(16'(db), 16'($urandom_range(10)), 16'(ll),
				3'($urandom_range(7)), 3'($urandom_range(7)));
			quiet = (phase == 5);
			start = beats_sent;
			while (beats_sent - start < 100) begin
				if ($urandom_range(99) < 80) begin
					press_for($urandom_range(db + 1), $urandom_range(ll + 3));
				end else begin
					repeat ($urandom_range(1, 4))
						send_beat(1'($urandom_range(1)), 1'($urandom_range(1)));
				end
				// In one stretch of one phase, hold off the sender until everything has come back
				if (phase == 8 && beats_sent - start >= 70 && beats_sent - start < 80)
					drain_results();
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_press_classes();
		test_debounce();
		test_limit_order();
		test_wraps_and_light();
		test_random();
		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
